/* src/kpw_pkg.sv */
`default_nettype none

package kpw_pkg;

   localparam int unsigned TIMER_W = 16;
   localparam int unsigned ELAPSED_W = 12;
   localparam int unsigned LEVEL_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned NUM_LEVELS = 4;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_PONG  = 2'd2,
      KIND_STOP  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PONG_TIMEOUT = 3'd0,
      CSR_PING_INTERVAL = 3'd1,
      CSR_SLOW_AFTER = 3'd2,
      CSR_LEVEL_EDGE_ONE = 3'd3,
      CSR_LEVEL_EDGE_TWO = 3'd4,
      CSR_LEVEL_EDGE_THREE = 3'd5,
      CSR_LEVEL_EDGE_FOUR = 3'd6,
      CSR_UNUSED = 3'd7
   } csr_index_type;

   localparam logic [TIMER_W-1:0] PONG_TIMEOUT_RST = 16'd15000;
   localparam logic [TIMER_W-1:0] PING_INTERVAL_RST = 16'd5000;
   localparam logic [TIMER_W-1:0] SLOW_AFTER_RST = 16'd5000;
   localparam logic [TIMER_W-1:0] LEVEL_EDGE_ONE_RST = 16'd100;
   localparam logic [TIMER_W-1:0] LEVEL_EDGE_TWO_RST = 16'd1000;
   localparam logic [TIMER_W-1:0] LEVEL_EDGE_THREE_RST = 16'd5000;
   localparam logic [TIMER_W-1:0] LEVEL_EDGE_FOUR_RST = 16'd10000;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'(NUM_LEVELS);

   typedef struct packed {
      kind_type             kind;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } req_payload_type;

   typedef struct packed {
      logic               send_ping;
      logic               link_lost;
      logic               link_slow;
      logic [LEVEL_W-1:0] quality_level;
      logic               awaiting_pong;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type      index;
      logic [TIMER_W-1:0] data;
   } csr_payload_type;

endpackage

`default_nettype wire

/* src/kpw_stream_if.sv */
`default_nettype none

interface kpw_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/keepalive_ping_watchdog_core.sv */
// Keepalive ping watchdog.
// req_if: one event per transfer (kind = tick, start, pong or stop; elapsed_ms
//   used by ticks only). rsp_if: exactly one result per event, in order:
//   send_ping, link_lost, link_slow, quality_level, awaiting_pong.
// csr_if: register writes (index 0..6: pong timeout, ping interval, slow limit,
//   four quality edges); always ready, index 7 is ignored. Write only while idle.
// Pipeline: an event is held in the input register, where it is evaluated
//   against the timer state; its result is loaded into the output register
//   once that register is empty or rsp_if takes its result, and rsp_if.valid
//   stays high while the output register holds a result.
// Throughput: one event per cycle while rsp_if keeps taking results; the timer
//   state updates as each event passes on, so each sees the state left by the last.
// Stall: when rsp_if is held off, the output register keeps its result and the
//   input register keeps the next event; req_if.ready drops only when both are
//   full, combinationally following rsp_if.ready.
// Reset: synchronous; registers return to defaults, the watchdog is stopped
//   with all timers cleared, and no result is pending.
`default_nettype none

module keepalive_ping_watchdog_core (
   input  wire logic          clock,
   input  wire logic          reset,
   kpw_stream_if.sink         req_if,
   kpw_stream_if.source       rsp_if,
   kpw_stream_if.sink         csr_if
);

   localparam int unsigned TW = kpw_pkg::TIMER_W;
   localparam int unsigned LW = kpw_pkg::LEVEL_W;

   // configuration
   logic [TW-1:0] timeout_ff, interval_ff, slow_after_ff;
   logic [TW-1:0] edge_ff [kpw_pkg::NUM_LEVELS];

   // watchdog state
   logic [TW-1:0] wait_timer_ff, wait_timer_in;
   logic [TW-1:0] retry_timer_ff, retry_timer_in;
   logic [TW-1:0] pause_timer_ff, pause_timer_in;
   logic          waiting_ff, waiting_in;
   logic          retry_armed_ff, retry_armed_in;
   logic          pause_armed_ff, pause_armed_in;
   logic          slow_ff, slow_in;
   logic          halted_ff, halted_in;
   logic [LW-1:0] levels_ff, levels_in;

   // pipeline
   logic                      s1_valid_ff;
   kpw_pkg::req_payload_type  s1_data_ff;
   logic                      rsp_valid_ff;
   kpw_pkg::rsp_payload_type  rsp_data_ff;
   kpw_pkg::rsp_payload_type  rsp_data_in;
   logic                      s1_fire;
   logic                      req_fire;

   logic [TW:0]   dt;
   logic [TW:0]   wait_sum, retry_sum, pause_sum;
   logic [TW-1:0] level_edge;
   logic          drop;
   logic          send_ping, lost_now;

   assign s1_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign dt = (TW+1)'(s1_data_ff.elapsed_ms);
   assign wait_sum  = {1'b0, wait_timer_ff} + dt;
   assign retry_sum = {1'b0, retry_timer_ff} + dt;
   assign pause_sum = {1'b0, pause_timer_ff} + dt;
   assign level_edge = edge_ff[levels_ff[1:0]];

   always_comb begin
      wait_timer_in  = wait_timer_ff;
      retry_timer_in = retry_timer_ff;
      pause_timer_in = pause_timer_ff;
      waiting_in     = waiting_ff;
      retry_armed_in = retry_armed_ff;
      pause_armed_in = pause_armed_ff;
      slow_in        = slow_ff;
      halted_in      = halted_ff;
      levels_in      = levels_ff;
      send_ping      = 1'b0;
      lost_now       = 1'b0;
      drop           = 1'b0;
      case (s1_data_ff.kind)
         kpw_pkg::KIND_TICK: begin
            if (!halted_ff) begin
               // wait section
               if (waiting_ff && (wait_timer_ff < timeout_ff)) begin
                  wait_timer_in = wait_sum[TW-1:0];
                  if ((levels_ff < kpw_pkg::LEVEL_MAX) &&
                      (wait_sum > {1'b0, level_edge})) begin
                     levels_in = levels_ff + LW'(1);
                  end
                  if (wait_sum > {1'b0, slow_after_ff}) begin
                     slow_in = 1'b1;
                  end
                  if (wait_sum >= {1'b0, timeout_ff}) begin
                     drop           = 1'b1;
                     lost_now       = 1'b1;
                     halted_in      = 1'b1;
                     waiting_in     = 1'b0;
                     pause_armed_in = 1'b0;
                     wait_timer_in  = '0;
                     pause_timer_in = '0;
                  end
               end
               // retry section
               if (retry_armed_ff && (retry_timer_ff < interval_ff)) begin
                  if (retry_sum >= {1'b0, interval_ff}) begin
                     retry_timer_in = '0;
                     send_ping      = 1'b1;
                  end else begin
                     retry_timer_in = retry_sum[TW-1:0];
                  end
               end
               // pause section; a drop in this tick disarms it
               if (!drop && pause_armed_ff && (pause_timer_ff < interval_ff)) begin
                  if (pause_sum >= {1'b0, interval_ff}) begin
                     halted_in      = 1'b0;
                     send_ping      = 1'b1;
                     retry_timer_in = '0;
                     retry_armed_in = 1'b1;
                     wait_timer_in  = '0;
                     pause_timer_in = '0;
                     pause_armed_in = 1'b0;
                     waiting_in     = 1'b1;
                     slow_in        = 1'b0;
                     levels_in      = '0;
                  end else begin
                     pause_timer_in = pause_sum[TW-1:0];
                  end
               end
            end
         end
         kpw_pkg::KIND_START: begin
            halted_in      = 1'b0;
            send_ping      = 1'b1;
            retry_timer_in = '0;
            retry_armed_in = 1'b1;
            wait_timer_in  = '0;
            pause_timer_in = '0;
            pause_armed_in = 1'b0;
            waiting_in     = 1'b1;
            slow_in        = 1'b0;
            levels_in      = '0;
         end
         kpw_pkg::KIND_PONG: begin
            wait_timer_in  = '0;
            pause_timer_in = '0;
            retry_timer_in = '0;
            retry_armed_in = 1'b0;
            pause_armed_in = 1'b1;
            waiting_in     = 1'b0;
            slow_in        = 1'b0;
         end
         default: begin
            halted_in = 1'b1;
         end
      endcase
      rsp_data_in.send_ping     = send_ping;
      rsp_data_in.link_lost     = lost_now;
      rsp_data_in.link_slow     = slow_in;
      rsp_data_in.quality_level = levels_in;
      rsp_data_in.awaiting_pong = waiting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= kpw_pkg::PONG_TIMEOUT_RST;
         interval_ff    <= kpw_pkg::PING_INTERVAL_RST;
         slow_after_ff  <= kpw_pkg::SLOW_AFTER_RST;
         edge_ff[0]     <= kpw_pkg::LEVEL_EDGE_ONE_RST;
         edge_ff[1]     <= kpw_pkg::LEVEL_EDGE_TWO_RST;
         edge_ff[2]     <= kpw_pkg::LEVEL_EDGE_THREE_RST;
         edge_ff[3]     <= kpw_pkg::LEVEL_EDGE_FOUR_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.data.index)
            kpw_pkg::CSR_PONG_TIMEOUT:     timeout_ff    <= csr_if.data.data;
            kpw_pkg::CSR_PING_INTERVAL:    interval_ff   <= csr_if.data.data;
            kpw_pkg::CSR_SLOW_AFTER:       slow_after_ff <= csr_if.data.data;
            kpw_pkg::CSR_LEVEL_EDGE_ONE:   edge_ff[0]    <= csr_if.data.data;
            kpw_pkg::CSR_LEVEL_EDGE_TWO:   edge_ff[1]    <= csr_if.data.data;
            kpw_pkg::CSR_LEVEL_EDGE_THREE: edge_ff[2]    <= csr_if.data.data;
            kpw_pkg::CSR_LEVEL_EDGE_FOUR:  edge_ff[3]    <= csr_if.data.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_timer_ff  <= '0;
         retry_timer_ff <= '0;
         pause_timer_ff <= '0;
         waiting_ff     <= 1'b0;
         retry_armed_ff <= 1'b0;
         pause_armed_ff <= 1'b0;
         slow_ff        <= 1'b0;
         halted_ff      <= 1'b1;
         levels_ff      <= '0;
      end else if (s1_fire) begin
         wait_timer_ff  <= wait_timer_in;
         retry_timer_ff <= retry_timer_in;
         pause_timer_ff <= pause_timer_in;
         waiting_ff     <= waiting_in;
         retry_armed_ff <= retry_armed_in;
         pause_armed_ff <= pause_armed_in;
         slow_ff        <= slow_in;
         halted_ff      <= halted_in;
         levels_ff      <= levels_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_if.data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
